// ===== rtl/core/tdb_pkg.sv =====
package tdb_pkg;

    // Default geometry of the display.
    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 32;

    // Fixed widths of the request and result fields.
    localparam int CHAR_W = 8;
    localparam int OP_W   = 2;
    localparam int ROW_FW = 3;
    localparam int COL_FW = 5;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Code shown in place of a character outside the printable range.
    localparam logic [CHAR_W-1:0] SPACE_CODE = 8'h20;

    // Register file.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_SEL_LOW  = 1'b0;
    localparam logic REG_SEL_HIGH = 1'b1;
    localparam logic [CHAR_W-1:0] LOW_RESET  = 8'd32;
    localparam logic [CHAR_W-1:0] HIGH_RESET = 8'd126;

endpackage

// ===== rtl/core/text_display_buffer.sv =====
// The result of a request accepted at one clock edge is shown, with its
// strobe o_result_valid, in the cycle that follows; the receiver cannot stall.
// Throughput: one request per cycle when not busy, set by the single write and the
// single registered read port of the memory, which a request uses at most once.
// Reset: synchronous, active low; busy stays high for one cycle after reset, and the
// memory needs no clearing pass, so the block is ready right away.
module text_display_buffer
    import tdb_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_op,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic [ROW_FW-1:0] i_read_row,
    input  logic [COL_FW-1:0] i_read_col,
    // Result channel.
    output logic              o_result_valid,
    output logic [CHAR_W-1:0] o_shown_char,
    output logic [ROW_FW-1:0] o_cursor_row_out,
    output logic [COL_FW-1:0] o_cursor_col_out,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    // Comparison widths wide enough for both the cursor and the request fields.
    localparam int RXW   = (RW > ROW_FW) ? RW : ROW_FW;
    localparam int CXW   = (CW > COL_FW) ? CW : COL_FW;
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    // The memory is never cleared. The cursor only ever enters a row through a
    // clear of that row (row wrap, full wrap, clear request or reset), and rows
    // below the cursor have not been touched since the last full clear. So the
    // live contents are exactly the cells before the cursor in row-major order:
    // a row above the cursor row, or the cursor row left of the cursor column.
    // Every other cell reads as zero whatever the array holds, which is how a
    // row clear and a whole-memory clear need no pass over the array at all.
    logic [CHAR_W-1:0] mem [DEPTH];

    logic              r_ready;
    logic [CHAR_W-1:0] r_low;
    logic [CHAR_W-1:0] r_high;
    logic [RW-1:0]     r_cur_row, n_cur_row;
    logic [CW-1:0]     r_cur_col, n_cur_col;
    logic              r_res_valid;
    logic              r_res_read;
    logic              r_res_hit;
    logic [ROW_FW-1:0] r_res_row;
    logic [COL_FW-1:0] r_res_col;
    logic [CHAR_W-1:0] r_rd_data;

    logic              accept;
    logic              rd_hit;
    logic [RXW-1:0]    req_row_x, cur_row_x, n_row_x;
    logic [CXW-1:0]    req_col_x, cur_col_x, n_col_x;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [CHAR_W-1:0] shown_raw;
    logic              printable;
    logic              cfg_wr;

    // The block takes a request in every cycle except the one right after reset.
    assign busy   = !r_ready;
    assign accept = start && !busy;

    // A read hits live data only before the cursor, and only inside the grid;
    // a request outside the grid therefore reads as zero.
    assign req_row_x = RXW'(i_read_row);
    assign cur_row_x = RXW'(r_cur_row);
    assign req_col_x = CXW'(i_read_col);
    assign cur_col_x = CXW'(r_cur_col);
    assign rd_hit    = ((req_row_x < cur_row_x) && (int'(i_read_col) < COLS)) ||
                       ((req_row_x == cur_row_x) && (req_col_x < cur_col_x));

    assign wr_addr = AW'(r_cur_row) * AW'(COLS) + AW'(r_cur_col);
    assign rd_addr = AW'(i_read_row) * AW'(COLS) + AW'(i_read_col);

    // Cursor after the request. A push advances the column; past the last
    // column it moves to the next row, and past the last row back to the origin.
    always_comb begin
        n_cur_row = r_cur_row;
        n_cur_col = r_cur_col;
        unique case (i_op)
            OP_PUSH: begin
                if (r_cur_col != LAST_COL) begin
                    n_cur_col = r_cur_col + 1'b1;
                end else begin
                    n_cur_col = '0;
                    if (r_cur_row != LAST_ROW) begin
                        n_cur_row = r_cur_row + 1'b1;
                    end else begin
                        n_cur_row = '0;
                    end
                end
            end
            OP_CLEAR: begin
                n_cur_row = '0;
                n_cur_col = '0;
            end
            default: begin
                // Reads and the unused code leave the cursor alone.
            end
        endcase
    end

    assign n_row_x = RXW'(n_cur_row);
    assign n_col_x = CXW'(n_cur_col);

    // Control and cursor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready     <= 1'b0;
            r_cur_row   <= '0;
            r_cur_col   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_ready     <= 1'b1;
            r_res_valid <= accept;
            if (accept) begin
                r_cur_row <= n_cur_row;
                r_cur_col <= n_cur_col;
            end
        end
    end

    // Result payload; it carries the cursor as it stands after the request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_read <= (i_op == OP_READ);
            r_res_hit  <= rd_hit;
            r_res_row  <= n_row_x[ROW_FW-1:0];
            r_res_col  <= n_col_x[COL_FW-1:0];
        end
    end

    // Character memory: one write port at the cursor, one registered read port.
    // A read right after a push sees the pushed character, since the write
    // lands at the edge before the read samples the array.
    always_ff @(posedge i_clk) begin
        if (accept && (i_op == OP_PUSH)) begin
            mem[wr_addr] <= i_char_code;
        end
        if (accept && (i_op == OP_READ) && rd_hit) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Readout: a cell that is not live reads as zero, and a code outside the
    // printable window shows as a space. An empty window gives a read a space always.
    assign shown_raw = r_res_hit ? r_rd_data : '0;
    assign printable = (shown_raw >= r_low) && (shown_raw <= r_high);

    assign o_result_valid   = r_res_valid;
    assign o_shown_char     = !r_res_read ? '0 : (printable ? shown_raw : SPACE_CODE);
    assign o_cursor_row_out = r_res_row;
    assign o_cursor_col_out = r_res_col;

    // Configuration registers: the word select is address bit 2.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= LOW_RESET;
            r_high <= HIGH_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SEL_LOW:  r_low  <= pwdata[CHAR_W-1:0];
                REG_SEL_HIGH: r_high <= pwdata[CHAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SEL_LOW:  prdata = APB_DW'(r_low);
            REG_SEL_HIGH: prdata = APB_DW'(r_high);
            default:      prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/tdb_checker.sv =====
module tdb_checker
    import tdb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [OP_W-1:0]   i_op,
    input logic [CHAR_W-1:0] i_char_code,
    input logic [ROW_FW-1:0] i_read_row,
    input logic [COL_FW-1:0] i_read_col,
    input logic              o_result_valid,
    input logic [CHAR_W-1:0] o_shown_char,
    input logic [ROW_FW-1:0] o_cursor_row_out,
    input logic [COL_FW-1:0] o_cursor_col_out,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    logic acc;
    assign acc = i_rst_n && start && !busy;

    // Every accepted request gives exactly one result, in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid == $past(acc))
        else $error("result strobe does not follow an accepted request");

    // Only a read shows a character.
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_op != OP_READ) |=> (o_shown_char == '0))
        else $error("non-read request shows a character");

    // A clear puts the cursor back at the origin.
    a_clear_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_op == OP_CLEAR) |=> (o_cursor_row_out == '0) && (o_cursor_col_out == '0))
        else $error("clear does not return the cursor to the origin");

    // Two reads in a row leave the cursor where it was.
    a_read_keeps_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_op == OP_READ) && $past(acc) && ($past(i_op) == OP_READ)
        |=> $stable(o_cursor_row_out) && $stable(o_cursor_col_out))
        else $error("read moved the cursor");

endmodule

bind text_display_buffer tdb_checker u_tdb_checker (.*);
